// ===== rtl/core/sst_pkg.sv =====
// shared types and constants of the set span tracker
`timescale 1ns / 1ps

package sst_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned MAX_COUNT_W  = 11;

	localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RST = 11'd1024;

	localparam logic [VALUE_W-1:0] LARGEST_RST  = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] SMALLEST_RST = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] BEST_GAP_RST = 32'hFFFF_FFFF;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_MAXS  = 6'b001000,
		ST_MINS  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// status returned by the shared gap unit
	typedef struct packed {
		logic [VALUE_W-1:0] gap;
		logic               a_gt_b;
		logic               lt_best;
	} gap_res_t;

endpackage

// ===== rtl/core/sst_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/sst_gap_unit.sv =====
// shared signed compare and absolute difference unit
`timescale 1ns / 1ps

module sst_gap_unit (
	input  logic [sst_pkg::VALUE_W-1:0] op_a,
	input  logic [sst_pkg::VALUE_W-1:0] op_b,
	input  logic [sst_pkg::VALUE_W-1:0] best,
	output sst_pkg::gap_res_t           res
);

	logic [sst_pkg::VALUE_W-1:0] key_a;
	logic [sst_pkg::VALUE_W-1:0] key_b;
	logic                        a_ge_b;
	logic [sst_pkg::VALUE_W-1:0] gap;

	// flip the sign bit so unsigned order matches signed order
	assign key_a  = {~op_a[sst_pkg::VALUE_W-1], op_a[sst_pkg::VALUE_W-2:0]};
	assign key_b  = {~op_b[sst_pkg::VALUE_W-1], op_b[sst_pkg::VALUE_W-2:0]};
	assign a_ge_b = key_a >= key_b;
	assign gap    = a_ge_b ? (op_a - op_b) : (op_b - op_a);

	assign res.gap     = gap;
	assign res.a_gt_b  = key_a > key_b;
	assign res.lt_best = gap < best;

endmodule

// ===== rtl/core/set_span_tracker.sv =====
// top level of the set span tracker: sequencer, value store and result register
`timescale 1ns / 1ps

// Set span tracker. Each request carries one signed 32-bit value. While fewer
// than min(max_count, CAPACITY) values are held, the value is appended to an
// on-chip store; otherwise it is dropped and the result shows accepted = 0.
// Every request gives exactly one result: the count held, the longest span
// (largest minus smallest held value) and the shortest span (least absolute
// difference between any two held values), both zero with spans_valid low
// while fewer than two values are held. An accepted value is walked
// against every stored value through the single read port of the store, one
// stored value per cycle, all through one shared compare/subtract unit; a
// dropped value goes straight to the result. in_ready is high only while the
// sequencer is idle; the result sits in an output register until taken, and a
// new request may be accepted meanwhile. The store needs no clearing after
// reset: only entries below the fill count are ever read. The user must write
// max_count through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this. A limit below the count held makes every
// further value be dropped until the limit is raised or the block is reset.
module set_span_tracker #(
	parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [sst_pkg::MAX_COUNT_W-1:0]     cfg_wdata,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sst_pkg::VALUE_W-1:0]  value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic [sst_pkg::MAX_COUNT_W-1:0]     stored_count,
	output logic                                spans_valid,
	output logic [sst_pkg::VALUE_W-1:0]         longest_span,
	output logic [sst_pkg::VALUE_W-1:0]         shortest_span
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned LW = (CW > sst_pkg::MAX_COUNT_W) ? CW : sst_pkg::MAX_COUNT_W;

	sst_pkg::state_t state_q;

	logic [sst_pkg::MAX_COUNT_W-1:0] max_count_q;
	logic [CW-1:0]                   held_q;
	logic [AW-1:0]                   idx_q;
	logic                            rd_pend_q;
	logic                            acc_q;
	logic [sst_pkg::VALUE_W-1:0]     value_q;
	logic [sst_pkg::VALUE_W-1:0]     largest_q;
	logic [sst_pkg::VALUE_W-1:0]     smallest_q;
	logic [sst_pkg::VALUE_W-1:0]     best_q;
	logic                            out_valid_q;

	logic                            in_fire;
	logic                            has_room;
	logic                            scan_last;
	logic                            out_load;
	logic                            two_held;
	logic                            ram_we;
	logic [sst_pkg::VALUE_W-1:0]     ram_rdata;
	logic [sst_pkg::VALUE_W-1:0]     op_a;
	logic [sst_pkg::VALUE_W-1:0]     op_b;
	sst_pkg::gap_res_t               unit_res;

	assign in_ready = (state_q == sst_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// room left under both the programmed limit and the store size
	assign has_room = (LW'(held_q) < LW'(max_count_q)) && (held_q < CW'(CAPACITY));

	// last stored entry being issued to the read port
	assign scan_last = ((CW'(idx_q) + CW'(1)) == held_q);

	assign two_held = (held_q >= CW'(2));
	assign out_load = (state_q == sst_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign ram_we   = (state_q == sst_pkg::ST_MINS);

	// operand steering for the shared unit
	always_comb begin
		case (state_q)
			sst_pkg::ST_SCAN, sst_pkg::ST_DRAIN: begin
				op_a = ram_rdata;
				op_b = value_q;
			end
			sst_pkg::ST_MAXS: begin
				op_a = value_q;
				op_b = largest_q;
			end
			sst_pkg::ST_MINS: begin
				op_a = smallest_q;
				op_b = value_q;
			end
			default: begin
				// longest span: largest minus smallest
				op_a = largest_q;
				op_b = smallest_q;
			end
		endcase
	end

	sst_gap_unit u_gap (
		.op_a (op_a),
		.op_b (op_b),
		.best (best_q),
		.res  (unit_res)
	);

	sst_ram #(
		.WIDTH (sst_pkg::VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (held_q[AW-1:0]),
		.wdata (value_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= sst_pkg::MAX_COUNT_RST;
		end else if (cfg_we) begin
			max_count_q <= cfg_wdata;
		end
	end

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sst_pkg::ST_IDLE;
			held_q     <= '0;
			idx_q      <= '0;
			rd_pend_q  <= 1'b0;
			acc_q      <= 1'b0;
			largest_q  <= sst_pkg::LARGEST_RST;
			smallest_q <= sst_pkg::SMALLEST_RST;
			best_q     <= sst_pkg::BEST_GAP_RST;
		end else begin
			case (state_q)
				sst_pkg::ST_IDLE: begin
					if (in_fire) begin
						acc_q <= has_room;
						idx_q <= '0;
						if (!has_room) begin
							state_q <= sst_pkg::ST_DONE;
						end else if (held_q == '0) begin
							state_q <= sst_pkg::ST_MAXS;
						end else begin
							state_q <= sst_pkg::ST_SCAN;
						end
					end
				end
				sst_pkg::ST_SCAN: begin
					// one read issued per cycle, data compared once the registered read returns
					rd_pend_q <= 1'b1;
					if (rd_pend_q && unit_res.lt_best) begin
						best_q <= unit_res.gap;
					end
					if (scan_last) begin
						state_q <= sst_pkg::ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				sst_pkg::ST_DRAIN: begin
					rd_pend_q <= 1'b0;
					if (rd_pend_q && unit_res.lt_best) begin
						best_q <= unit_res.gap;
					end
					state_q <= sst_pkg::ST_MAXS;
				end
				sst_pkg::ST_MAXS: begin
					if (unit_res.a_gt_b) begin
						largest_q <= value_q;
					end
					state_q <= sst_pkg::ST_MINS;
				end
				sst_pkg::ST_MINS: begin
					// value written to the store this cycle
					if (unit_res.a_gt_b) begin
						smallest_q <= value_q;
					end
					held_q  <= held_q + CW'(1);
					state_q <= sst_pkg::ST_DONE;
				end
				sst_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= sst_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sst_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request value held for the whole walk
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted      <= acc_q;
			stored_count  <= sst_pkg::MAX_COUNT_W'(held_q);
			spans_valid   <= two_held;
			longest_span  <= two_held ? unit_res.gap : '0;
			shortest_span <= two_held ? best_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	// fill count never passes the store size
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("fill count above store size");

	// a walk only starts with something stored
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_SCAN) |-> (held_q != '0))
		else $error("walk over an empty store");

	// fill count grows by one on the store write and holds otherwise
	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_MINS) |=> (held_q == $past(held_q) + CW'(1)))
		else $error("fill count did not advance on store write");

	a_held_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sst_pkg::ST_MINS) |=> $stable(held_q))
		else $error("fill count changed outside store write");

	// read data is only pending during the walk
	a_rd_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (state_q == sst_pkg::ST_SCAN || state_q == sst_pkg::ST_DRAIN))
		else $error("pending read outside walk");

endmodule
